// ===== hdl/ttsa_pkg.sv =====
// Shared constants and types for the tensor tile store address core.
package ttsa_pkg;

   // Field and register widths
   localparam int BATCH_W = 16;
   localparam int CHAN_W  = 16;
   localparam int POS_W   = 24;
   localparam int CNT_W   = 4;
   localparam int DATA_W  = 64;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int IDX_W   = 3;
   localparam int OFF_W   = 58;

   // Parameter defaults
   localparam int TILE_DEF        = 8;
   localparam int PADDED_TAIL_DEF = 1;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_BATCH_COUNT     = 3'd0;
   localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd1;
   localparam logic [IDX_W-1:0] REG_SPATIAL_TOTAL   = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW_WIDTH       = 3'd3;
   localparam logic [IDX_W-1:0] REG_BATCH_STRIDE    = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW_STRIDE      = 3'd5;
   localparam logic [IDX_W-1:0] REG_POSITION_STRIDE = 3'd6;
   localparam logic [IDX_W-1:0] REG_STORAGE_SPAN    = 3'd7;

   // Item state that rides alongside the address arithmetic
   typedef struct packed {
      logic              bad;
      logic              pad;
      logic [CHAN_W-1:0] chan;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] data;
   } side_type;

   // Item state inside the divider stages
   typedef struct packed {
      side_type           side;
      logic [BATCH_W-1:0] batch;
      logic [POS_W-1:0]   rem;
      logic [POS_W-1:0]   quo;
   } div_item_type;

endpackage

// ===== hdl/tensor_tile_store_address_core.sv =====
// An accepted start reaches rsp_strobe through one input register, 24 divider stages,
// four multiply/add stages and one output register.
// Throughput: one command per cycle; busy is low except during reset.
// The row/column split runs one quotient bit per stage through a 24-stage divider.
// Reset is synchronous: it empties the pipeline and restores register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tensor_tile_store_address_core #(
   parameter int TILE        = ttsa_pkg::TILE_DEF,
   parameter int PADDED_TAIL = ttsa_pkg::PADDED_TAIL_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ttsa_pkg::BATCH_W-1:0] req_batch_index,
   input  logic [ttsa_pkg::CHAN_W-1:0]  req_first_channel,
   input  logic [ttsa_pkg::POS_W-1:0]   req_position_index,
   input  logic [ttsa_pkg::CNT_W-1:0]   req_valid_count,
   input  logic [ttsa_pkg::DATA_W-1:0]  req_tile_data,
   output logic                         rsp_strobe,
   output logic [ttsa_pkg::STAT_W-1:0]  rsp_status,
   output logic [ttsa_pkg::WORD_W-1:0]  rsp_write_offset,
   output logic [ttsa_pkg::CNT_W-1:0]   rsp_write_count,
   output logic [ttsa_pkg::DATA_W-1:0]  rsp_write_data,
   input  logic                         csr_write_en,
   input  logic [ttsa_pkg::IDX_W-1:0]   csr_index,
   input  logic [ttsa_pkg::WORD_W-1:0]  csr_wdata
);
   import ttsa_pkg::*;

   localparam int DIV_W   = POS_W;
   localparam int LATENCY = DIV_W + 6;
   localparam logic [CNT_W-1:0]  TILE_CNT  = CNT_W'(TILE);
   localparam logic [DATA_W-1:0] TILE_MASK =
      (TILE >= 8) ? {DATA_W{1'b1}} : ((DATA_W'(1) << (8 * TILE)) - DATA_W'(1));

   // Configuration registers
   logic [BATCH_W-1:0] batch_count_ff;
   logic [CHAN_W-1:0]  channel_count_ff;
   logic [POS_W-1:0]   spatial_total_ff;
   logic [POS_W-1:0]   row_width_ff;
   logic [WORD_W-1:0]  batch_stride_ff;
   logic [WORD_W-1:0]  row_stride_ff;
   logic [WORD_W-1:0]  position_stride_ff;
   logic [WORD_W-1:0]  storage_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff     <= BATCH_W'(1);
         channel_count_ff   <= CHAN_W'(1);
         spatial_total_ff   <= POS_W'(1);
         row_width_ff       <= POS_W'(1);
         batch_stride_ff    <= '0;
         row_stride_ff      <= '0;
         position_stride_ff <= '0;
         storage_span_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_BATCH_COUNT:     batch_count_ff     <= csr_wdata[BATCH_W-1:0];
            REG_CHANNEL_COUNT:   channel_count_ff   <= csr_wdata[CHAN_W-1:0];
            REG_SPATIAL_TOTAL:   spatial_total_ff   <= csr_wdata[POS_W-1:0];
            REG_ROW_WIDTH:       row_width_ff       <= csr_wdata[POS_W-1:0];
            REG_BATCH_STRIDE:    batch_stride_ff    <= csr_wdata;
            REG_ROW_STRIDE:      row_stride_ff      <= csr_wdata;
            REG_POSITION_STRIDE: position_stride_ff <= csr_wdata;
            REG_STORAGE_SPAN:    storage_span_ff    <= csr_wdata;
            default:             ;
         endcase
      end
   end

   assign busy = reset;

   // Argument checks at the input
   logic              accept;
   logic [CHAN_W:0]   chan_end;
   logic              arg_bad;
   logic              tail_pad;
   div_item_type      div_in  [0:DIV_W];
   div_item_type      div_ff  [0:DIV_W];
   logic              div_vld_ff [0:DIV_W];

   assign accept = start & ~busy;

   always_comb begin
      chan_end = {1'b0, req_first_channel} + (CHAN_W+1)'(req_valid_count);
      arg_bad  = (req_batch_index >= batch_count_ff) ||
                 (req_position_index >= spatial_total_ff) ||
                 (req_valid_count == '0) || (req_valid_count > TILE_CNT) ||
                 (chan_end > {1'b0, channel_count_ff});
      tail_pad = (PADDED_TAIL != 0) && (req_valid_count < TILE_CNT) &&
                 (chan_end == {1'b0, channel_count_ff}) &&
                 (({1'b0, (WORD_W)'(req_first_channel)} + (WORD_W+1)'(TILE)) <=
                  {1'b0, position_stride_ff});
      div_in[0].side.bad   = arg_bad;
      div_in[0].side.pad   = tail_pad;
      div_in[0].side.chan  = req_first_channel;
      div_in[0].side.count = req_valid_count;
      div_in[0].side.data  = req_tile_data & TILE_MASK;
      div_in[0].batch      = req_batch_index;
      div_in[0].rem        = '0;
      div_in[0].quo        = req_position_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else begin
         div_vld_ff[0] <= accept;
      end
   end

   always_ff @(posedge clock) begin
      div_ff[0] <= div_in[0];
   end

   // Restoring divider: one quotient bit per stage
   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      logic [DIV_W:0] part;
      logic           ge;

      always_comb begin
         part          = {div_ff[i].rem, div_ff[i].quo[DIV_W-1]};
         ge            = (part >= {1'b0, row_width_ff});
         div_in[i+1]   = div_ff[i];
         div_in[i+1].rem = ge ? DIV_W'(part - {1'b0, row_width_ff}) : part[DIV_W-1:0];
         div_in[i+1].quo = {div_ff[i].quo[DIV_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[i+1] <= 1'b0;
         end else begin
            div_vld_ff[i+1] <= div_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         div_ff[i+1] <= div_in[i+1];
      end
   end

   // Multiply stage: partial products, row and position strides split into 16-bit halves
   logic [POS_W-1:0]          row_in;
   logic [POS_W-1:0]          col_in;
   logic                      m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff;
   side_type                  m1_side_ff, m2_side_ff, m3_side_ff, m4_side_ff;
   logic [BATCH_W+WORD_W-1:0] bprod_ff;
   logic [POS_W+15:0]         rlo_ff, rhi_ff, clo_ff, chi_ff;
   logic [BATCH_W+WORD_W-1:0] bprod2_ff;
   logic [POS_W+WORD_W-1:0]   rowp_ff, colp_ff;
   logic [BATCH_W+WORD_W:0]   sum_b_ff;
   logic [POS_W+WORD_W:0]     sum_rc_ff;
   logic [OFF_W-1:0]          offset_ff;

   // Zero row width means one unbounded row
   assign row_in = (row_width_ff == '0) ? '0 : div_ff[DIV_W].quo;
   assign col_in = div_ff[DIV_W].rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= div_vld_ff[DIV_W];
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_side_ff <= div_ff[DIV_W].side;
      bprod_ff   <= (BATCH_W+WORD_W)'(div_ff[DIV_W].batch) *
                    (BATCH_W+WORD_W)'(batch_stride_ff);
      rlo_ff     <= (POS_W+16)'(row_in) * (POS_W+16)'(row_stride_ff[15:0]);
      rhi_ff     <= (POS_W+16)'(row_in) * (POS_W+16)'(row_stride_ff[31:16]);
      clo_ff     <= (POS_W+16)'(col_in) * (POS_W+16)'(position_stride_ff[15:0]);
      chi_ff     <= (POS_W+16)'(col_in) * (POS_W+16)'(position_stride_ff[31:16]);

      // Combine halves
      m2_side_ff <= m1_side_ff;
      bprod2_ff  <= bprod_ff;
      rowp_ff    <= (POS_W+WORD_W)'(rlo_ff) + {rhi_ff, 16'b0};
      colp_ff    <= (POS_W+WORD_W)'(clo_ff) + {chi_ff, 16'b0};

      // Pairwise sums
      m3_side_ff <= m2_side_ff;
      sum_b_ff   <= (BATCH_W+WORD_W+1)'(bprod2_ff) + (BATCH_W+WORD_W+1)'(m2_side_ff.chan);
      sum_rc_ff  <= (POS_W+WORD_W+1)'(rowp_ff) + (POS_W+WORD_W+1)'(colp_ff);

      m4_side_ff <= m3_side_ff;
      offset_ff  <= OFF_W'(sum_b_ff) + OFF_W'(sum_rc_ff);
   end

   // Final checks against the storage span
   logic [OFF_W:0] end_tile;
   logic [OFF_W:0] end_valid;
   logic           fits_tile;
   logic           widen;
   logic           over;

   always_comb begin
      end_tile  = {1'b0, offset_ff} + (OFF_W+1)'(TILE);
      end_valid = {1'b0, offset_ff} + (OFF_W+1)'(m4_side_ff.count);
      fits_tile = (end_tile <= (OFF_W+1)'(storage_span_ff));
      widen     = m4_side_ff.pad && fits_tile;
      over      = ~widen && (end_valid > (OFF_W+1)'(storage_span_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= m4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m4_side_ff.bad) begin
         rsp_status       <= ST_INVALID;
         rsp_write_offset <= '0;
         rsp_write_count  <= '0;
         rsp_write_data   <= '0;
      end else if (over) begin
         rsp_status       <= ST_OVERFLOW;
         rsp_write_offset <= '0;
         rsp_write_count  <= '0;
         rsp_write_data   <= '0;
      end else begin
         rsp_status       <= ST_OK;
         rsp_write_offset <= offset_ff[WORD_W-1:0];
         rsp_write_count  <= widen ? TILE_CNT : m4_side_ff.count;
         rsp_write_data   <= m4_side_ff.data;
      end
   end

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result missing after accepted command");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching command");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_write_count == '0 && rsp_write_offset == '0 && rsp_write_data == '0))
      else $error("error result carries a nonzero field");

   a_ok_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_OK) |->
         (rsp_write_count != '0 && rsp_write_count <= TILE_CNT))
      else $error("ok result with bad byte count");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the tensor tile store address core.
`timescale 1ns / 1ps

module tb;
   import ttsa_pkg::*;

   localparam int TILE            = TILE_DEF;
   localparam int PADDED_TAIL     = PADDED_TAIL_DEF;
   localparam int DIRECTED_PHASES = 5;
   localparam int RANDOM_PHASES   = 30;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int DRAIN_LIMIT     = 200;
   localparam int SETTLE_CYCLES   = 40;

   typedef logic [7:0][WORD_W-1:0] reg_file_type;

   typedef enum int {PLAN_SHAPED, PLAN_WILD, PLAN_HUGE, PLAN_EMPTY} plan_kind_type;

   typedef struct packed {
      logic [BATCH_W-1:0] batch;
      logic [CHAN_W-1:0]  chan;
      logic [POS_W-1:0]   pos;
      logic [CNT_W-1:0]   valid;
      logic [DATA_W-1:0]  data;
   } store_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] offset;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] data;
   } store_result_type;

   typedef struct {
      int               phase;
      store_cmd_type    cmd;
      bit               fixed;
      store_result_type res;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [BATCH_W-1:0]  req_batch_index;
   logic [CHAN_W-1:0]   req_first_channel;
   logic [POS_W-1:0]    req_position_index;
   logic [CNT_W-1:0]    req_valid_count;
   logic [DATA_W-1:0]   req_tile_data;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [WORD_W-1:0]   rsp_write_offset;
   logic [CNT_W-1:0]    rsp_write_count;
   logic [DATA_W-1:0]   rsp_write_data;
   logic                csr_write_en;
   logic [IDX_W-1:0]    csr_index;
   logic [WORD_W-1:0]   csr_wdata;

   store_result_type pending_stores[$];
   directed_row_type directed_rows[$];
   reg_file_type     directed_plans[1:DIRECTED_PHASES-1];
   reg_file_type     reg_shadow;

   int error_count;
   int stores_sent;
   int stores_ok;
   int stores_invalid;
   int stores_overflow;
   int tails_widened;
   int plans_loaded;

   tensor_tile_store_address_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_batch_index    (req_batch_index),
      .req_first_channel  (req_first_channel),
      .req_position_index (req_position_index),
      .req_valid_count    (req_valid_count),
      .req_tile_data      (req_tile_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_write_offset   (rsp_write_offset),
      .rsp_write_count    (rsp_write_count),
      .rsp_write_data     (rsp_write_data),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("watchdog expired with %0d stores pending", pending_stores.size());
      $display("tensor_tile_store_address_core test failed");
      $finish;
   end

   function automatic void note_error(input string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endfunction

   function automatic reg_file_type make_plan(input longint bc, cc, st, rw, bs, rs, ps,
                                              span);
      reg_file_type v;
      v[REG_BATCH_COUNT]     = WORD_W'(bc);
      v[REG_CHANNEL_COUNT]   = WORD_W'(cc);
      v[REG_SPATIAL_TOTAL]   = WORD_W'(st);
      v[REG_ROW_WIDTH]       = WORD_W'(rw);
      v[REG_BATCH_STRIDE]    = WORD_W'(bs);
      v[REG_ROW_STRIDE]      = WORD_W'(rs);
      v[REG_POSITION_STRIDE] = WORD_W'(ps);
      v[REG_STORAGE_SPAN]    = WORD_W'(span);
      return v;
   endfunction

   // Byte offset, tail widening and bounds check for one tile store.
   function automatic store_result_type predict_store(input store_cmd_type c);
      store_result_type r;
      longint unsigned nb, nc, st, rw, bs, rs, ps, span;
      longint unsigned batch, chan, pos, row, col, offs, cnt, chan_end;
      logic [DATA_W-1:0] data_mask;
      nb   = reg_shadow[REG_BATCH_COUNT];
      nc   = reg_shadow[REG_CHANNEL_COUNT];
      st   = reg_shadow[REG_SPATIAL_TOTAL];
      rw   = reg_shadow[REG_ROW_WIDTH];
      bs   = reg_shadow[REG_BATCH_STRIDE];
      rs   = reg_shadow[REG_ROW_STRIDE];
      ps   = reg_shadow[REG_POSITION_STRIDE];
      span = reg_shadow[REG_STORAGE_SPAN];
      batch = c.batch;
      chan  = c.chan;
      pos   = c.pos;
      cnt   = c.valid;
      chan_end = chan + cnt;
      r = '0;
      if (batch >= nb || pos >= st || cnt == 0 || cnt > TILE || chan_end > nc) begin
         r.status = ST_INVALID;
         return r;
      end
      // zero row width means one unbounded row
      if (rw == 0) begin
         row = 0;
         col = pos;
      end else begin
         row = pos / rw;
         col = pos % rw;
      end
      offs = batch * bs + chan + row * rs + col * ps;
      if (PADDED_TAIL != 0 && cnt < TILE && chan_end == nc && chan + TILE <= ps &&
          offs + TILE <= span) begin
         cnt = TILE;
      end
      if (offs + cnt > span) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      data_mask = (TILE >= 8) ? '1 : ((DATA_W'(1) << (8 * TILE)) - 1);
      r.status = ST_OK;
      r.offset = WORD_W'(offs);
      r.count  = CNT_W'(cnt);
      r.data   = c.data & data_mask;
      return r;
   endfunction

   function automatic longint pick_below(input longint limit);
      if (limit == 0) return $urandom_range(0, 255);
      if ($urandom_range(0, 7) == 0) return limit - 1;
      return $urandom_range(0, int'(limit - 1));
   endfunction

   function automatic store_cmd_type random_cmd(input bit shaped);
      store_cmd_type c;
      longint nc;
      c.data = {$urandom, $urandom};
      if (!shaped) begin
         c.batch = BATCH_W'($urandom);
         c.chan  = CHAN_W'($urandom);
         c.pos   = POS_W'($urandom);
         c.valid = CNT_W'($urandom);
         return c;
      end
      nc = reg_shadow[REG_CHANNEL_COUNT];
      c.batch = BATCH_W'(pick_below(reg_shadow[REG_BATCH_COUNT]));
      c.pos   = POS_W'(pick_below(reg_shadow[REG_SPATIAL_TOTAL]));
      c.valid = CNT_W'($urandom_range(1, TILE));
      if (nc < c.valid) c.chan = CHAN_W'($urandom_range(0, 40));
      else if ($urandom_range(0, 2) == 0) c.chan = CHAN_W'(nc - c.valid);
      else c.chan = CHAN_W'($urandom_range(0, int'(nc - c.valid)));
      return c;
   endfunction

   function automatic reg_file_type random_plan(input plan_kind_type kind);
      reg_file_type v;
      longint bc, cc, st, rw, rows, cols, ps, rs, bs, span;
      if (kind == PLAN_WILD) begin
         for (int i = 0; i < 8; i++) v[i] = $urandom;
      end else if (kind == PLAN_HUGE) begin
         v = make_plan(65535, 65535, 24'hFF_FFFF,
                       $urandom_range(0, 1) ? 24'hFF_FFFF : 0,
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom,
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 1),
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 64),
                       32'hFFFF_FFFF);
      end else begin
         // laid out the way plan creation would, with the span trimmed near the end
         bc = $urandom_range(1, 4);
         cc = $urandom_range(1, 40);
         st = $urandom_range(1, 64);
         case ($urandom_range(0, 3))
            0: rw = 0;
            1: rw = $urandom_range(1, int'(st));
            2: rw = st + $urandom_range(0, 5);
            default: rw = $urandom_range(1, 8);
         endcase
         if (rw == 0) begin
            rows = 1;
            cols = st;
         end else begin
            rows = (st + rw - 1) / rw;
            cols = (rw < st) ? rw : st;
         end
         ps = ($urandom_range(0, 5) == 0) ? $urandom_range(0, int'(cc)) :
                                            cc + $urandom_range(0, 9);
         rs = cols * ps + $urandom_range(0, 16);
         bs = rows * rs + $urandom_range(0, 16);
         span = (bc - 1) * bs + (rows - 1) * rs + (cols - 1) * ps + cc +
                $urandom_range(0, 8) - $urandom_range(0, 8);
         if (span < 0) span = 0;
         v = make_plan(bc, cc, st, rw, bs, rs, ps, span);
         if (kind == PLAN_EMPTY) begin
            case ($urandom_range(0, 2))
               0: v[REG_BATCH_COUNT] = '0;
               1: v[REG_CHANNEL_COUNT] = '0;
               default: v[REG_SPATIAL_TOTAL] = '0;
            endcase
         end
      end
      // junk above the register width must be dropped
      if ($urandom_range(0, 2) == 0) begin
         v[REG_BATCH_COUNT][31:16]   = $urandom;
         v[REG_CHANNEL_COUNT][31:16] = $urandom;
         v[REG_SPATIAL_TOTAL][31:24] = $urandom;
         v[REG_ROW_WIDTH][31:24]     = $urandom;
      end
      return v;
   endfunction

   task automatic program_regs(input reg_file_type vals);
      for (int i = 0; i <= int'(REG_STORAGE_SPAN); i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= IDX_W'(i);
         csr_wdata    <= vals[i];
         @(posedge clock);
         case (IDX_W'(i))
            REG_BATCH_COUNT, REG_CHANNEL_COUNT: reg_shadow[i] = vals[i] & 32'h0000_FFFF;
            REG_SPATIAL_TOTAL, REG_ROW_WIDTH:   reg_shadow[i] = vals[i] & 32'h00FF_FFFF;
            default:                            reg_shadow[i] = vals[i];
         endcase
      end
      csr_write_en <= 1'b0;
      plans_loaded++;
   endtask

   // Hold off until every pending store has come back; drop any that never do.
   task automatic drain_results();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (pending_stores.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_stores.size() != 0) begin
         note_error($sformatf("%0d stores never returned", pending_stores.size()));
         pending_stores.delete();
      end
   endtask

   task automatic send_store(input store_cmd_type cmd, input bit fixed,
                             input store_result_type fixed_res, input int gap);
      store_result_type want;
      start              <= 1'b1;
      req_batch_index    <= cmd.batch;
      req_first_channel  <= cmd.chan;
      req_position_index <= cmd.pos;
      req_valid_count    <= cmd.valid;
      req_tile_data      <= cmd.data;
      do @(posedge clock); while (busy !== 1'b0);
      want = fixed ? fixed_res : predict_store(cmd);
      pending_stores.push_back(want);
      stores_sent++;
      case (want.status)
         ST_OK: begin
            stores_ok++;
            if (want.count != cmd.valid) tails_widened++;
         end
         ST_INVALID: stores_invalid++;
         default:    stores_overflow++;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_row(input int phase, input longint batch, chan, pos, valid,
                                   input logic [DATA_W-1:0] data, input bit fixed,
                                   input logic [STAT_W-1:0] status, input longint offs,
                                   input longint cnt, input logic [DATA_W-1:0] wdata);
      directed_row_type r;
      r.phase      = phase;
      r.cmd.batch  = BATCH_W'(batch);
      r.cmd.chan   = CHAN_W'(chan);
      r.cmd.pos    = POS_W'(pos);
      r.cmd.valid  = CNT_W'(valid);
      r.cmd.data   = data;
      r.fixed      = fixed;
      r.res.status = status;
      r.res.offset = WORD_W'(offs);
      r.res.count  = CNT_W'(cnt);
      r.res.data   = wdata;
      directed_rows.push_back(r);
   endfunction

   // Compare each result transfer against the oldest pending store.
   always @(posedge clock) begin
      store_result_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_stores.size() == 0) begin
            note_error($sformatf("unexpected result: status %0d offset %h count %0d data %h",
                                 rsp_status, rsp_write_offset, rsp_write_count,
                                 rsp_write_data));
         end else begin
            want = pending_stores.pop_front();
            if (rsp_status !== want.status || rsp_write_offset !== want.offset ||
                rsp_write_count !== want.count || rsp_write_data !== want.data) begin
               note_error($sformatf({"mismatch: expected status %0d offset %h count %0d ",
                                     "data %h, got status %0d offset %h count %0d data %h"},
                                    want.status, want.offset, want.count, want.data,
                                    rsp_status, rsp_write_offset, rsp_write_count,
                                    rsp_write_data));
            end
         end
      end
   end

   initial begin
      int            gap;
      bit            idle_on;
      plan_kind_type kind;

      error_count     = 0;
      stores_sent     = 0;
      stores_ok       = 0;
      stores_invalid  = 0;
      stores_overflow = 0;
      tails_widened   = 0;
      plans_loaded    = 0;
      reg_shadow      = make_plan(1, 1, 1, 1, 0, 0, 0, 0);

      reset              <= 1'b1;
      start              <= 1'b0;
      req_batch_index    <= '0;
      req_first_channel  <= '0;
      req_position_index <= '0;
      req_valid_count    <= '0;
      req_tile_data      <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;

      directed_plans[1] = make_plan(4, 20, 12, 5, 1000, 100, 24, 2244);
      directed_plans[2] = make_plan(65535, 65535, 24'hFF_FFFF, 0, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      directed_plans[3] = make_plan(65535, 65535, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 1,
                                    32'hFFFF_FFFF);
      directed_plans[4] = make_plan(0, 0, 0, 0, 0, 0, 0, 0);

      // after reset: nothing fits an empty buffer
      add_row(0, 0, 0, 0, 1, '1, 1'b1, ST_OVERFLOW, 0, 0, '0);
      add_row(0, 1, 0, 0, 1, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(0, 0, 0, 0, 0, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(0, 0, 1, 0, 1, '1, 1'b1, ST_INVALID, 0, 0, '0);
      // small plan: full tile, widened tail, tails held back by capacity and span
      add_row(1, 0, 0, 0, 8, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK, 0, 8,
              64'h0123_4567_89AB_CDEF);
      add_row(1, 0, 16, 0, 4, '1, 1'b0, ST_OK, 0, 0, '0);
      add_row(1, 0, 17, 0, 3, 64'h5555_AAAA_5555_AAAA, 1'b0, ST_OK, 0, 0, '0);
      add_row(1, 2, 16, 11, 4, 64'hAAAA_5555_AAAA_5555, 1'b0, ST_OK, 0, 0, '0);
      add_row(1, 2, 12, 11, 8, 64'h8000_0000_0000_0001, 1'b0, ST_OK, 0, 0, '0);
      add_row(1, 1, 4, 7, 2, 64'h0F0F_F0F0_3C3C_C3C3, 1'b0, ST_OK, 0, 0, '0);
      add_row(1, 3, 0, 0, 1, '1, 1'b1, ST_OVERFLOW, 0, 0, '0);
      add_row(1, 4, 0, 0, 1, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(1, 0, 0, 12, 1, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(1, 0, 0, 0, 9, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(1, 0, 0, 0, 15, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(1, 0, 13, 0, 8, '1, 1'b1, ST_INVALID, 0, 0, '0);
      add_row(1, 0, 65535, 0, 8, '1, 1'b1, ST_INVALID, 0, 0, '0);
      // everything at its maximum, unbounded row
      add_row(2, 0, 0, 0, 8, '1, 1'b1, ST_OK, 0, 8, '1);
      add_row(2, 0, 65527, 0, 8, 64'hFEDC_BA98_7654_3210, 1'b1, ST_OK, 65527, 8,
              64'hFEDC_BA98_7654_3210);
      add_row(2, 0, 65534, 0, 1, 64'h1122_3344_5566_7788, 1'b0, ST_OK, 0, 0, '0);
      add_row(2, 65534, 0, 0, 1, '1, 1'b0, ST_OK, 0, 0, '0);
      add_row(2, 0, 0, 24'hFF_FFFE, 1, '1, 1'b0, ST_OK, 0, 0, '0);
      // widest row, unit strides
      add_row(3, 65534, 65534, 24'hFF_FFFE, 1, '1, 1'b0, ST_OK, 0, 0, '0);
      // all registers zero
      add_row(4, 0, 0, 0, 1, '1, 1'b1, ST_INVALID, 0, 0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < DIRECTED_PHASES; ph++) begin
         if (ph > 0) begin
            drain_results();
            program_regs(directed_plans[ph]);
         end
         foreach (directed_rows[k]) begin
            if (directed_rows[k].phase == ph) begin
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
               send_store(directed_rows[k].cmd, directed_rows[k].fixed,
                          directed_rows[k].res, gap);
            end
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 8)
            5:       kind = PLAN_WILD;
            6:       kind = PLAN_HUGE;
            7:       kind = PLAN_EMPTY;
            default: kind = PLAN_SHAPED;
         endcase
         drain_results();
         program_regs(random_plan(kind));
         // no idling in the closing phases
         idle_on = (p < RANDOM_PHASES - 4) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
            send_store(random_cmd($urandom_range(0, 4) != 0), 1'b0, '0, gap);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d tile stores across %0d register plans: %0d ok (%0d tails widened)",
               stores_sent, plans_loaded + 1, stores_ok, tails_widened);
      $display("%0d rejected as invalid, %0d as overflow, %0d mismatches",
               stores_invalid, stores_overflow, error_count);
      if (error_count == 0) begin
         $display("tensor_tile_store_address_core test passed");
      end else begin
         $display("tensor_tile_store_address_core test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ttsa_pkg.sv
hdl/tensor_tile_store_address_core.sv
tb/tb.sv
